// ===== hdl/poi_pkg.sv =====
// ----------------------------------------------------------------------------
// poi_pkg
// shared types, constants and the cordic arctangent table for the odometry
// integrator
// ----------------------------------------------------------------------------
package poi_pkg;

  localparam int unsigned AtanEntries = 24;

  localparam logic signed [18:0] PiQ16    = 19'sd205887;
  localparam logic signed [19:0] TwoPiQ16 = 20'sd411775;
  localparam logic signed [34:0] HalfPiQ30 = 35'sd1686629713;
  localparam logic signed [34:0] PiQ30     = 35'sd3373259426;
  localparam logic signed [34:0] GainQ30   = 35'sd652032874;
  localparam logic signed [47:0] PosMax = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] PosMin = {1'b1, {47{1'b0}}};

  // datapath commands from the controller
  typedef struct packed {
    logic load;      // capture input beat
    logic clear;     // zero the pose
    logic cordic;    // one micro-rotation
    logic mul_step;  // advance multiply sequence
    logic wrap;      // one heading wrap step
    logic commit;    // write new pose and output register
  } poi_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic wrap_done;
  } poi_sts_t;

  function automatic logic signed [31:0] atan_q30(input logic [4:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0:  v = 32'sd843314857;
      5'd1:  v = 32'sd497837830;
      5'd2:  v = 32'sd263043837;
      5'd3:  v = 32'sd133525159;
      5'd4:  v = 32'sd67021687;
      5'd5:  v = 32'sd33543516;
      5'd6:  v = 32'sd16775851;
      5'd7:  v = 32'sd8388438;
      5'd8:  v = 32'sd4194283;
      5'd9:  v = 32'sd2097150;
      5'd10: v = 32'sd1048576;
      5'd11: v = 32'sd524288;
      5'd12: v = 32'sd262144;
      5'd13: v = 32'sd131072;
      5'd14: v = 32'sd65536;
      5'd15: v = 32'sd32768;
      5'd16: v = 32'sd16384;
      5'd17: v = 32'sd8192;
      5'd18: v = 32'sd4096;
      5'd19: v = 32'sd2048;
      5'd20: v = 32'sd1024;
      5'd21: v = 32'sd512;
      5'd22: v = 32'sd256;
      5'd23: v = 32'sd128;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/poi_ctrl.sv =====
// ----------------------------------------------------------------------------
// poi_ctrl
// sequencer: accept beat, run cordic, multiply sequence, heading wrap, emit
// ----------------------------------------------------------------------------
module poi_ctrl #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_clear,
  input  logic              in_skip,
  output logic              out_valid,
  input  logic              out_ready,
  output poi_pkg::poi_cmd_t cmd,
  input  poi_pkg::poi_sts_t sts
);
  import poi_pkg::*;

  localparam int unsigned CntW = $clog2(CORDIC_STAGES + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ROT   = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_WRAP  = 6'b001000,
    ST_DONE  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd = '0;
    in_ready = 1'b0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          cnt_nxt = '0;
          if (in_clear) begin
            cmd.clear = 1'b1;
            state_nxt = ST_DONE;
          end else if (in_skip) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_ROT;
          end
        end
      end
      ST_ROT: begin
        cmd.cordic = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CntW'(CORDIC_STAGES - 1)) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_done) state_nxt = ST_WRAP;
      end
      ST_WRAP: begin
        cmd.wrap = 1'b1;
        if (sts.wrap_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/poi_dp.sv =====
// ----------------------------------------------------------------------------
// poi_dp
// pose registers, shared cordic, sequenced multiplier and heading wrap
// ----------------------------------------------------------------------------
module poi_dp #(
  parameter int unsigned CORDIC_STAGES  = 16,
  parameter int unsigned MAX_WRAP_TURNS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  poi_pkg::poi_cmd_t   cmd,
  output poi_pkg::poi_sts_t   sts,
  input  logic signed [31:0]  in_vx,
  input  logic signed [31:0]  in_vy,
  input  logic signed [31:0]  in_wz,
  input  logic signed [31:0]  in_dt,
  output logic signed [47:0]  pose_x,
  output logic signed [47:0]  pose_y,
  output logic signed [18:0]  heading,
  output logic                sat
);
  import poi_pkg::*;

  localparam int unsigned CntW = $clog2(CORDIC_STAGES + 1);
  localparam longint LimV = longint'(MAX_WRAP_TURNS) * 411775;

  // pose state
  logic signed [47:0] px_r, py_r;
  logic signed [18:0] hd_r;
  // output register
  logic signed [47:0] ox_r, oy_r;
  logic signed [18:0] oh_r;
  logic               os_r;
  // captured beat
  logic signed [31:0] vx_r, vy_r, wz_r, dt_r;
  // cordic
  logic signed [34:0] cx_r, cy_r, cz_r;
  logic               flip_r;
  logic [CntW-1:0]    ci_r;
  // multiply sequence
  logic [3:0]         ph_r;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [66:0] acc_r;
  logic signed [36:0] gx_r, gy_r;
  logic signed [47:0] nx_r, ny_r;
  logic signed [47:0] inc_r;
  logic               sat_r;
  // wrap
  logic signed [25:0] h_r;

  logic signed [34:0] zin, sx, sy;
  logic signed [31:0] cosr, sinr;

  always_comb begin
    zin = 35'(hd_r) <<< 14;
    sx = cx_r >>> ci_r;
    sy = cy_r >>> ci_r;
    cosr = flip_r ? -32'(cx_r) : 32'(cx_r);
    sinr = flip_r ? -32'(cy_r) : 32'(cy_r);
  end

  // product operands per phase; wide factors split into 32 bit halves
  always_comb begin
    ma = '0;
    mb = '0;
    case (ph_r)
      4'd0: begin ma = vx_r; mb = cosr; end
      4'd1: begin ma = vy_r; mb = sinr; end
      4'd2: begin ma = vx_r; mb = sinr; end
      4'd3: begin ma = vy_r; mb = cosr; end
      4'd4: begin ma = 32'(gx_r); mb = dt_r; end
      4'd5: begin ma = 32'(gy_r); mb = dt_r; end
      4'd6: begin ma = 32'(gx_r >>> 32); mb = dt_r; end
      4'd7: begin ma = 32'(gy_r >>> 32); mb = dt_r; end
      4'd8: begin ma = wz_r; mb = dt_r; end
      default: ;
    endcase
  end

  // unsigned low half for the split products
  logic [63:0] prod_lo;
  assign prod = ma * mb;
  assign prod_lo = {32'd0, ma[31:0]} * {32'd0, mb};

  logic signed [66:0] lo_x_r, lo_y_r;
  logic signed [66:0] full;
  logic signed [49:0] dsum;
  logic signed [66:0] rv;

  // rounding and position sums per phase
  always_comb begin
    full = '0;
    rv = '0;
    dsum = '0;
    case (ph_r)
      4'd1: rv = (acc_r - 67'(prod) + (67'sd1 <<< 29)) >>> 30;
      4'd3: rv = (acc_r + 67'(prod) + (67'sd1 <<< 29)) >>> 30;
      4'd6: begin
        full = lo_x_r + (67'(prod) <<< 32);
        rv = (full + (67'sd1 <<< 15)) >>> 16;
        dsum = 50'(nx_r) + 50'(rv);
      end
      4'd7: begin
        full = lo_y_r + (67'(prod) <<< 32);
        rv = (full + (67'sd1 <<< 15)) >>> 16;
        dsum = 50'(ny_r) + 50'(rv);
      end
      4'd8: rv = (67'(prod) + (67'sd1 <<< 15)) >>> 16;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0;
      py_r <= '0;
      hd_r <= '0;
    end else begin
      if (cmd.clear) begin
        px_r <= '0;
        py_r <= '0;
        hd_r <= '0;
      end else if (cmd.commit) begin
        px_r <= nx_r;
        py_r <= ny_r;
        hd_r <= 19'(h_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vx_r <= in_vx;
      vy_r <= in_vy;
      wz_r <= in_wz;
      dt_r <= in_dt;
      ci_r <= '0;
      ph_r <= '0;
      sat_r <= 1'b0;
      nx_r <= cmd.clear ? '0 : px_r;
      ny_r <= cmd.clear ? '0 : py_r;
      h_r <= cmd.clear ? '0 : 26'(hd_r);
      cx_r <= GainQ30;
      cy_r <= '0;
      if (zin > HalfPiQ30) begin
        cz_r <= zin - PiQ30;
        flip_r <= 1'b1;
      end else if (zin < -HalfPiQ30) begin
        cz_r <= zin + PiQ30;
        flip_r <= 1'b1;
      end else begin
        cz_r <= zin;
        flip_r <= 1'b0;
      end
    end
    if (cmd.cordic) begin
      ci_r <= ci_r + 1'b1;
      if (!cz_r[34]) begin
        cx_r <= cx_r - sy;
        cy_r <= cy_r + sx;
        cz_r <= cz_r - 35'(atan_q30(5'(ci_r)));
      end else begin
        cx_r <= cx_r + sy;
        cy_r <= cy_r - sx;
        cz_r <= cz_r + 35'(atan_q30(5'(ci_r)));
      end
    end
    if (cmd.mul_step) begin
      ph_r <= ph_r + 1'b1;
      case (ph_r)
        4'd0: acc_r <= 67'(prod);
        4'd1: begin
          gx_r <= 37'(rv);
          acc_r <= '0;
        end
        4'd2: acc_r <= 67'(prod);
        4'd3: gy_r <= 37'(rv);
        4'd4: lo_x_r <= 67'($signed({1'b0, prod_lo}));
        4'd5: lo_y_r <= 67'($signed({1'b0, prod_lo}));
        4'd6: begin
          if (dsum > 50'(PosMax)) begin nx_r <= PosMax; sat_r <= 1'b1; end
          else if (dsum < 50'(PosMin)) begin nx_r <= PosMin; sat_r <= 1'b1; end
          else nx_r <= 48'(dsum);
        end
        4'd7: begin
          if (dsum > 50'(PosMax)) begin ny_r <= PosMax; sat_r <= 1'b1; end
          else if (dsum < 50'(PosMin)) begin ny_r <= PosMin; sat_r <= 1'b1; end
          else ny_r <= 48'(dsum);
        end
        4'd8: inc_r <= 48'(rv);
        4'd9: begin
          if (inc_r > 48'(LimV)) begin
            h_r <= h_r + 26'(LimV);
            sat_r <= 1'b1;
          end else if (inc_r < -48'(LimV)) begin
            h_r <= h_r - 26'(LimV);
            sat_r <= 1'b1;
          end else begin
            h_r <= h_r + 26'(inc_r);
          end
        end
        default: ;
      endcase
    end
    if (cmd.wrap) begin
      if (h_r > 26'(PiQ16)) h_r <= h_r - 26'(TwoPiQ16);
      else if (h_r < -26'(PiQ16)) h_r <= h_r + 26'(TwoPiQ16);
    end
    if (cmd.commit) begin
      ox_r <= nx_r;
      oy_r <= ny_r;
      oh_r <= 19'(h_r);
      os_r <= sat_r;
    end
  end

  assign sts.mul_done = (ph_r == 4'd9);
  assign sts.wrap_done = (h_r <= 26'(PiQ16)) && (h_r >= -26'(PiQ16));

  assign pose_x = ox_r;
  assign pose_y = oy_r;
  assign heading = oh_r;
  assign sat = os_r;

endmodule

// ===== hdl/planar_odometry_integrator_unit.sv =====
// ----------------------------------------------------------------------------
// planar_odometry_integrator_unit
// dead-reckoning pose integrator: cordic heading rotation, position and
// heading update with saturation and wrap
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  in_      | input     | in_valid / in_ready   | velocities, yaw rate, step, clear
//  out_     | output    | out_valid / out_ready | pose x, y, heading, saturated
//
//  an integrating beat runs the shared cordic stage, then the multiply sequence
//  on the 32x32 multipliers, then the heading wrap, at most MAX_WRAP_TURNS
//  steps; a clear or skipped beat goes straight to the commit
//  one beat is in work at a time; the output register holds a result while
//  the next beat is taken, and a full output register stalls the finish
//  rst_n is synchronous and zeroes the pose
module planar_odometry_integrator_unit #(
  parameter int unsigned CORDIC_STAGES  = 16,
  parameter int unsigned MAX_WRAP_TURNS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_body_vel_x,
  input  logic signed [31:0] in_body_vel_y,
  input  logic signed [31:0] in_yaw_rate,
  input  logic signed [31:0] in_time_step,
  input  logic               in_clear_pose,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] out_pose_x_out,
  output logic signed [47:0] out_pose_y_out,
  output logic signed [18:0] out_heading_out,
  output logic               out_saturated
);
  import poi_pkg::*;

  poi_cmd_t cmd;
  poi_sts_t sts;
  logic skip;

  assign skip = (in_time_step <= 32'sd0);

  poi_ctrl #(.CORDIC_STAGES(CORDIC_STAGES)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_clear(in_clear_pose), .in_skip(skip),
    .out_valid, .out_ready, .cmd, .sts
  );

  poi_dp #(.CORDIC_STAGES(CORDIC_STAGES), .MAX_WRAP_TURNS(MAX_WRAP_TURNS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_vx(in_body_vel_x), .in_vy(in_body_vel_y),
    .in_wz(in_yaw_rate), .in_dt(in_time_step),
    .pose_x(out_pose_x_out), .pose_y(out_pose_y_out),
    .heading(out_heading_out), .sat(out_saturated)
  );

endmodule

// ===== hdl/poi_checker.sv =====
// ----------------------------------------------------------------------------
// poi_checker
// port-level checks on the odometry integrator
// ----------------------------------------------------------------------------
module poi_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [47:0] out_pose_x_out,
  input logic signed [18:0] out_heading_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pose_x_out))
    else $error("result beat dropped while stalled");

  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_heading_out <= 19'sd205887) && (out_heading_out >= -19'sd205887))
    else $error("heading outside range");

  a_no_double_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while busy");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind planar_odometry_integrator_unit poi_checker u_poi_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_pose_x_out, .out_heading_out
);

// ===== test/planar_odometry_integrator_unit_chk.sv =====
// ----------------------------------------------------------------------------
// planar_odometry_integrator_unit_chk
// watches both channels of the odometry integrator, keeps its own copy of the
// pose, predicts each output beat and compares it field by field
// ----------------------------------------------------------------------------
module planar_odometry_integrator_unit_chk #(
  parameter int unsigned CORDIC_STAGES  = 16,
  parameter int unsigned MAX_WRAP_TURNS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] in_body_vel_x,
  input  logic signed [31:0] in_body_vel_y,
  input  logic signed [31:0] in_yaw_rate,
  input  logic signed [31:0] in_time_step,
  input  logic               in_clear_pose,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [47:0] out_pose_x_out,
  input  logic signed [47:0] out_pose_y_out,
  input  logic signed [18:0] out_heading_out,
  input  logic               out_saturated,
  output int                 err_count,
  output int                 pending_poses
);
  timeunit 1ns;
  timeprecision 1ps;
  import poi_pkg::*;

  typedef struct packed {
    logic signed [47:0] x;
    logic signed [47:0] y;
    logic signed [18:0] hdg;
    logic               sat;
  } pose_t;

  pose_t pose_q[$];
  longint trk_x, trk_y, trk_h;
  longint atan_tab[24] = '{843314857, 497837830, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388438, 4194283, 2097150, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

  assign pending_poses = pose_q.size();

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp48(longint v, inout logic sat);
    if (v > 64'sd140737488355327) begin
      sat = 1'b1;
      return 64'sd140737488355327;
    end
    if (v < -64'sd140737488355328) begin
      sat = 1'b1;
      return -64'sd140737488355328;
    end
    return v;
  endfunction

  task automatic integrate_beat(longint vx, longint vy, longint wz, longint dt,
                                logic clr);
    longint z, cx, sy, nx, gx, gy, inc, lim, h;
    logic flip, sat;
    pose_t p;
    sat = 1'b0;
    if (clr) begin
      trk_x = 0;
      trk_y = 0;
      trk_h = 0;
    end else if (dt > 0) begin
      z = trk_h * 16384;
      cx = 652032874;
      sy = 0;
      flip = 1'b0;
      if (z > 64'sd1686629713) begin
        z -= 64'sd3373259426;
        flip = 1'b1;
      end else if (z < -64'sd1686629713) begin
        z += 64'sd3373259426;
        flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
        if (z >= 0) begin
          nx = cx - (sy >>> i);
          sy = sy + (cx >>> i);
          z -= atan_tab[i];
        end else begin
          nx = cx + (sy >>> i);
          sy = sy - (cx >>> i);
          z += atan_tab[i];
        end
        cx = nx;
      end
      if (flip) begin
        cx = -cx;
        sy = -sy;
      end
      gx = round_shift(vx * cx - vy * sy, 30);
      gy = round_shift(vx * sy + vy * cx, 30);
      trk_x = clamp48(trk_x + round_shift(gx * dt, 16), sat);
      trk_y = clamp48(trk_y + round_shift(gy * dt, 16), sat);
      inc = round_shift(wz * dt, 16);
      lim = longint'(MAX_WRAP_TURNS) * 411775;
      if (inc > lim) begin
        inc = lim;
        sat = 1'b1;
      end else if (inc < -lim) begin
        inc = -lim;
        sat = 1'b1;
      end
      h = trk_h + inc;
      while (h > 205887) h -= 411775;
      while (h < -205887) h += 411775;
      trk_h = h;
    end
    p.x = trk_x[47:0];
    p.y = trk_y[47:0];
    p.hdg = trk_h[18:0];
    p.sat = sat;
    pose_q.push_back(p);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  initial err_count = 0;

  always @(posedge clk) begin
    pose_t w;
    if (!rst_n) begin
      trk_x <= 0;
      trk_y <= 0;
      trk_h <= 0;
      pose_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pose_q.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          w = pose_q.pop_front();
          if (out_pose_x_out !== w.x) report_mismatch("pose_x", out_pose_x_out, w.x);
          if (out_pose_y_out !== w.y) report_mismatch("pose_y", out_pose_y_out, w.y);
          if (out_heading_out !== w.hdg)
            report_mismatch("heading", out_heading_out, w.hdg);
          if (out_saturated !== w.sat) report_mismatch("saturated", out_saturated, w.sat);
        end
      end
      if (in_valid && in_ready)
        integrate_beat(in_body_vel_x, in_body_vel_y, in_yaw_rate, in_time_step,
                       in_clear_pose);
    end
  end
endmodule

// ===== test/planar_odometry_integrator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// planar_odometry_integrator_unit_tb
// drives directed and random velocity beats into the odometry integrator under
// several idle and stall patterns; the checker predicts and compares poses
// ----------------------------------------------------------------------------
module planar_odometry_integrator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 20000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_body_vel_x = '0;
  logic signed [31:0] in_body_vel_y = '0;
  logic signed [31:0] in_yaw_rate = '0;
  logic signed [31:0] in_time_step = '0;
  logic               in_clear_pose = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [47:0] out_pose_x_out;
  logic signed [47:0] out_pose_y_out;
  logic signed [18:0] out_heading_out;
  logic               out_saturated;
  int                 err_count;
  int                 pending_poses;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  bit                 hold_recv = 1'b0;
  int                 quiet_cycles = 0;

  always #2 clk = ~clk;

  planar_odometry_integrator_unit u_top (.*);

  planar_odometry_integrator_unit_chk u_chk (.*);

  // receiver
  always @(negedge clk) begin
    out_ready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on accepted beats
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_beat(logic signed [31:0] vx, logic signed [31:0] vy,
                           logic signed [31:0] wz, logic signed [31:0] dt, logic clr);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid <= 1'b1;
    in_body_vel_x <= vx;
    in_body_vel_y <= vy;
    in_yaw_rate <= wz;
    in_time_step <= dt;
    in_clear_pose <= clr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1, 0) ? 32'sh7fffffff : 32'sh80000000;
      2: return $signed($urandom_range(262144)) - 32'sd131072;
      default: return $signed($urandom_range(2097152)) - 32'sd1048576;
    endcase
  endfunction

  task automatic random_beat();
    logic signed [31:0] dt;
    case ($urandom_range(9))
      0: dt = -$signed($urandom_range(65536));
      1: dt = $urandom;
      2: dt = 32'sh7fffffff;
      default: dt = $urandom_range(65536, 1);
    endcase
    send_beat(pick_word(), pick_word(), pick_word(), dt, $urandom_range(39) == 0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_beat(32'sh00010000, 0, 32'sh00010000, 32'sh00010000, 1'b0);
    send_beat(32'sh00010000, 32'sh00010000, 32'sh00030000, 32'sh00010000, 1'b0);
    send_beat(32'sh7fffffff, 32'sh7fffffff, 0, 32'sh7fffffff, 1'b0);
    send_beat(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
    send_beat(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 1'b0);
    send_beat(32'sh00020000, 0, 32'sh80000000, 32'sh00010000, 1'b0);
    send_beat(32'sh12345678, 32'sh12345678, 32'sh00010000, 0, 1'b0);
    send_beat(32'sh12345678, 32'sh12345678, 32'sh00010000, 32'sh80000000, 1'b0);
    send_beat(32'sh12345678, 32'sh12345678, 32'sh00010000, 32'shffffffff, 1'b0);
    send_beat(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1'b1);
    send_beat(0, 32'sh00010000, 32'sh00032449, 32'sh00010000, 1'b0);
    send_beat(32'sh00010000, 0, 32'sh00032449, 32'sh00010000, 1'b0);
    send_beat(32'sh00010000, 0, 32'shfffcdbb7, 32'sh00020000, 1'b0);
    send_beat(32'sh00010000, 32'shffff0000, 32'sh00001000, 32'sh00000001, 1'b0);
    send_beat(0, 0, 0, 32'sh00000001, 1'b1);

    // long receiver hold-off so the input stalls
    hold_recv = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        hold_recv = 1'b0;
      end
      repeat (6) random_beat();
    join

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 78 : 31) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 78 : 31) : 0;
      repeat (105) random_beat();
      // let the pipeline drain before the next phase
      while (pending_poses != 0) @(negedge clk);
    end

    repeat (100) @(negedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
